// ===== rtl/redo_log_transaction_tracker_top_macros.svh =====
// Assertion macros shared by the redo log tracker RTL.
`ifndef REDO_LOG_TRANSACTION_TRACKER_TOP_MACROS_SVH
`define REDO_LOG_TRANSACTION_TRACKER_TOP_MACROS_SVH

// A property checked on every rising edge of clk_i outside reset.
`define RLT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never hold outside reset.
`define RLT_NEVER(name, expr, msg) \
  `RLT_ASSERT(name, !(expr), msg)

`endif

// ===== rtl/rlt_pkg.sv =====
// Types and constants of the redo log transaction tracker.
`default_nettype none

package rlt_pkg;

  localparam int unsigned LOG_ENTRIES_DEF = 32;

  localparam int unsigned BLK_W      = 32;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned CNT_OUT_W  = 6;
  localparam int unsigned OPS_W      = 6;
  localparam int unsigned AREA_W     = 8;
  localparam int unsigned RSV_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned NEED_W     = 14;

  localparam logic [OPS_W-1:0]  OPS_MAX  = 6'd63;
  localparam logic [AREA_W-1:0] AREA_RST = 8'd33;
  localparam logic [RSV_W-1:0]  RSV_RST  = 6'd10;

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_WAIT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_BIG = 3'd2;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_OP   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG_AREA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_RSV   = 2'd1;

  typedef struct packed {
    logic tok_en;
    logic shift;
    logic wr_en;
  } rlt_cell_ctl_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic                 absorbed;
    logic                 copy_valid;
    logic [SLOT_W-1:0]    slot;
    logic [BLK_W-1:0]     home_block;
    logic                 last;
    logic [CNT_OUT_W-1:0] entries_now;
    logic [OPS_W-1:0]     open_ops_now;
  } rlt_res_t;

endpackage

`default_nettype wire

// ===== rtl/rlt_cell.sv =====
// One slot of the logged block table: stores a block, matches the search token, shifts on commit.
`default_nettype none

module rlt_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IW    = 5
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  rlt_pkg::rlt_cell_ctl_t    ctl_i,
  input  wire [rlt_pkg::BLK_W-1:0]  key_i,
  input  wire [IW-1:0]              wr_idx_i,
  input  wire [rlt_pkg::BLK_W-1:0]  wr_data_i,
  input  wire [rlt_pkg::BLK_W-1:0]  shift_data_i,
  input  wire                       tok_i,
  output logic                      tok_o,
  output logic                      hit_o,
  output logic [rlt_pkg::BLK_W-1:0] data_o
);

  import rlt_pkg::*;

  logic [BLK_W-1:0] data_q;
  logic             tok_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && (wr_idx_i == IW'(INDEX))) begin
      data_q <= wr_data_i;
    end else if (ctl_i.shift) begin
      data_q <= shift_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= ctl_i.tok_en & tok_i;
    end
  end

  assign tok_o  = tok_q;
  assign hit_o  = tok_q && (data_q == key_i);
  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/redo_log_transaction_tracker_top.sv =====
// Top level of the redo log transaction tracker: control sequencer, cell row and result register.
`default_nettype none

`include "redo_log_transaction_tracker_top_macros.svh"

// The block takes one command at a time. Begin, end without commit and any refused or
// ignored command are taken in S_IDLE and give their result beat from S_EXEC once the
// output side is free, as the block returns to S_IDLE. A write walks a search token along
// the row of table cells, one cell per cycle, and loads its result beat from S_WFIN once
// the output side is free. A commit shifts the row towards its head by one cell per output
// beat: after S_IDLE and S_EXEC, S_CMIT loads the copy result beats, one every cycle when
// the output side does not stall. The table needs no clearing after reset; the logged
// count alone says which cells hold data.
module redo_log_transaction_tracker_top #(
  parameter int unsigned LOG_ENTRIES = rlt_pkg::LOG_ENTRIES_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [rlt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [rlt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire [rlt_pkg::CMD_W-1:0]       command_i,
  input  wire [rlt_pkg::BLK_W-1:0]       block_number_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [rlt_pkg::STAT_W-1:0]     status_o,
  output logic                           absorbed_o,
  output logic                           copy_valid_o,
  output logic [rlt_pkg::SLOT_W-1:0]     slot_o,
  output logic [rlt_pkg::BLK_W-1:0]      home_block_o,
  output logic                           last_o,
  output logic [rlt_pkg::CNT_OUT_W-1:0]  entries_now_o,
  output logic [rlt_pkg::OPS_W-1:0]      open_ops_now_o
);

  import rlt_pkg::*;

  localparam int unsigned IW = $clog2(LOG_ENTRIES);
  localparam int unsigned CW = $clog2(LOG_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_WFIN = 3'd3;
  localparam logic [2:0] S_CMIT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [BLK_W-1:0]  key_q, key_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [OPS_W-1:0]  ops_q, ops_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     n_q, n_d;
  logic              hit_q, hit_d;
  logic [AREA_W-1:0] area_q;
  logic [RSV_W-1:0]  rsv_q;
  logic              out_vld_q, out_vld_d;
  rlt_res_t          res_q, res_d;

  logic              out_free;
  logic              load;
  logic              inject;
  logic              any_hit;
  logic              full;
  logic [OPS_W:0]    ops_inc;
  logic [NEED_W-1:0] need;
  rlt_cell_ctl_t     ctl;

  logic [LOG_ENTRIES:0]   tok_w;
  logic [LOG_ENTRIES-1:0] hit_w;
  logic [BLK_W-1:0]       data_w [LOG_ENTRIES];

  for (genvar g = 0; g < LOG_ENTRIES; g++) begin : g_cell
    logic [BLK_W-1:0] shift_in;
    if (g == LOG_ENTRIES - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_body
      assign shift_in = data_w[g+1];
    end
    rlt_cell #(
      .INDEX(g),
      .IW   (IW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .key_i       (key_q),
      .wr_idx_i    (idx_q),
      .wr_data_i   (key_q),
      .shift_data_i(shift_in),
      .tok_i       (tok_w[g]),
      .tok_o       (tok_w[g+1]),
      .hit_o       (hit_w[g]),
      .data_o      (data_w[g])
    );
  end

  assign tok_w[0] = inject;
  assign any_hit  = |hit_w;
  assign out_free = !out_vld_q || out_ready_i;
  assign ops_inc  = {1'b0, ops_q} + (OPS_W + 1)'(1);
  assign need     = NEED_W'(cnt_q) + NEED_W'(ops_inc) * NEED_W'(rsv_q);
  assign full     = (cnt_q >= CW'(LOG_ENTRIES)) ||
                    ((9'(cnt_q) + 9'd1) >= {1'b0, area_q});

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    ops_d      = ops_q;
    idx_d      = idx_q;
    n_d        = n_q;
    hit_d      = hit_q;
    load       = 1'b0;
    inject     = 1'b0;
    in_ready_o = 1'b0;
    ctl.tok_en = (state_q == S_EXEC) || (state_q == S_SRCH);
    ctl.shift  = 1'b0;
    ctl.wr_en  = 1'b0;
    res_d      = '0;
    res_d.last = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = command_i;
          key_d   = block_number_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          case (cmd_q)
            CMD_BEGIN: begin
              load = 1'b1;
              if ((ops_q == OPS_MAX) || (need > NEED_W'(LOG_ENTRIES))) begin
                res_d.status = ST_WAIT;
              end else begin
                ops_d = ops_q + OPS_W'(1);
              end
            end
            CMD_END: begin
              if (ops_q == '0) begin
                load         = 1'b1;
                res_d.status = ST_NO_OP;
              end else if ((ops_q != OPS_W'(1)) || (cnt_q == '0)) begin
                load  = 1'b1;
                ops_d = ops_q - OPS_W'(1);
              end else begin
                ops_d   = '0;
                n_d     = cnt_q;
                cnt_d   = '0;
                idx_d   = '0;
                state_d = S_CMIT;
              end
            end
            CMD_WRITE: begin
              if (full) begin
                load         = 1'b1;
                res_d.status = ST_TOO_BIG;
              end else if (ops_q == '0) begin
                load         = 1'b1;
                res_d.status = ST_OUTSIDE;
              end else if (cnt_q == '0) begin
                hit_d   = 1'b0;
                idx_d   = '0;
                state_d = S_WFIN;
              end else begin
                inject  = 1'b1;
                idx_d   = '0;
                state_d = S_SRCH;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (any_hit) begin
          hit_d   = 1'b1;
          state_d = S_WFIN;
        end else if ((CW'(idx_q) + CW'(1)) == cnt_q) begin
          hit_d   = 1'b0;
          idx_d   = IW'(cnt_q);
          state_d = S_WFIN;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_WFIN: begin
        if (out_free) begin
          load             = 1'b1;
          res_d.absorbed   = hit_q;
          res_d.slot       = SLOT_W'(idx_q);
          res_d.home_block = key_q;
          ctl.wr_en        = !hit_q;
          if (!hit_q) begin
            cnt_d = cnt_q + CW'(1);
          end
          state_d = S_IDLE;
        end
      end
      S_CMIT: begin
        if (out_free) begin
          load             = 1'b1;
          ctl.shift        = 1'b1;
          res_d.copy_valid = 1'b1;
          res_d.slot       = SLOT_W'(idx_q);
          res_d.home_block = data_w[0];
          res_d.last       = (CW'(idx_q) + CW'(1)) == n_q;
          idx_d            = idx_q + IW'(1);
          if (res_d.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.entries_now  = CNT_OUT_W'(cnt_d);
    res_d.open_ops_now = ops_d;

    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ops_q     <= '0;
      idx_q     <= '0;
      n_q       <= '0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
      area_q    <= AREA_RST;
      rsv_q     <= RSV_RST;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ops_q     <= ops_d;
      idx_q     <= idx_d;
      n_q       <= n_d;
      hit_q     <= hit_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOG_AREA: area_q <= cfg_data_i[AREA_W-1:0];
          CFG_OP_RSV:   rsv_q  <= cfg_data_i[RSV_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = res_q.status;
  assign absorbed_o     = res_q.absorbed;
  assign copy_valid_o   = res_q.copy_valid;
  assign slot_o         = res_q.slot;
  assign home_block_o   = res_q.home_block;
  assign last_o         = res_q.last;
  assign entries_now_o  = res_q.entries_now;
  assign open_ops_now_o = res_q.open_ops_now;

  `RLT_NEVER(a_cnt_bound, cnt_q > CW'(LOG_ENTRIES), "logged count beyond table size")
  `RLT_ASSERT(a_srch_tok, (state_q == S_SRCH) |-> $onehot(tok_w[LOG_ENTRIES:1]), "search token lost")
  `RLT_ASSERT(a_srch_idx, (state_q == S_SRCH) |-> (CW'(idx_q) < cnt_q), "search past logged entries")
  `RLT_ASSERT(a_cmit_clr, (state_q == S_CMIT) |-> ((cnt_q == '0) && (ops_q == '0)), "commit with live counts")

endmodule

`default_nettype wire
